// File: sv/mcit_pkg.sv
// Package for the masked-compare interrupt timer.
// Holds payload types, access modes, register offsets and control bit positions.
// No dependencies.
package mcit_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [7:0]  offset_t;
    typedef logic [31:0] word_t;
    typedef logic [3:0]  ctrl_t;

    // access modes
    localparam mode_t MODE_TICK  = 2'd0;
    localparam mode_t MODE_READ  = 2'd1;
    localparam mode_t MODE_WRITE = 2'd2;

    // register byte offsets
    localparam offset_t OFF_COMPARE = 8'h00;
    localparam offset_t OFF_MASK    = 8'h04;
    localparam offset_t OFF_CONTROL = 8'h08;
    localparam offset_t OFF_COUNTER = 8'h0C;

    // control bit positions
    localparam int CTL_FLAG      = 0;
    localparam int CTL_CLR_MATCH = 1;
    localparam int CTL_DEBUG     = 2;
    localparam int CTL_ENABLE    = 3;

    localparam word_t COMPARE_RESET = 32'hFFFF_FFFF;

endpackage

// File: sv/masked_compare_interrupt_timer.sv
// Masked-compare repetitive interrupt timer: register file, counter and compare.
// Depends on mcit_pkg.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode, offset, write_data
//   out      out_valid / out_ready  read_data, irq
//
// One item per cycle sustained while the result side is not stalled. An accepted
// item is held in the input register; the register update and the read mux run in
// the pass into the result register. A stalled result holds the input register
// full, after which in_ready drops. Reset puts the registers at their defaults and
// empties both stages.
module masked_compare_interrupt_timer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mcit_pkg::mode_t   mode,
    input  mcit_pkg::offset_t offset,
    input  mcit_pkg::word_t   write_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mcit_pkg::word_t   read_data,
    output logic             irq
);
    import mcit_pkg::*;

    // input stage
    logic    s1_valid_reg;
    mode_t   s1_mode_reg;
    offset_t s1_offset_reg;
    word_t   s1_data_reg;

    // timer registers
    word_t cmp_reg,  cmp_next;
    word_t mask_reg, mask_next;
    ctrl_t ctrl_reg, ctrl_next;
    word_t cnt_reg,  cnt_next;

    // result stage
    logic  out_valid_reg;
    word_t rdata_reg, rdata_next;
    logic  irq_reg;

    logic  adv;
    word_t cnt_inc;
    logic  match;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    assign cnt_inc = cnt_reg + 32'd1;
    assign match   = ((cnt_inc ^ cmp_reg) & ~mask_reg) == '0;

    always_comb
    begin
        cmp_next   = cmp_reg;
        mask_next  = mask_reg;
        ctrl_next  = ctrl_reg;
        cnt_next   = cnt_reg;
        rdata_next = '0;
        case (s1_mode_reg)
            MODE_TICK:
            begin
                if (ctrl_reg[CTL_ENABLE])
                begin
                    cnt_next = cnt_inc;
                    if (match)
                    begin
                        ctrl_next[CTL_FLAG] = 1'b1;
                        if (ctrl_reg[CTL_CLR_MATCH])
                        begin
                            cnt_next = '0;
                        end
                    end
                end
            end
            MODE_READ:
            begin
                case (s1_offset_reg)
                    OFF_COMPARE: rdata_next = cmp_reg;
                    OFF_MASK:    rdata_next = mask_reg;
                    OFF_CONTROL: rdata_next = {28'd0, ctrl_reg};
                    OFF_COUNTER: rdata_next = cnt_reg;
                    default:     rdata_next = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (s1_offset_reg)
                    OFF_COMPARE: cmp_next  = s1_data_reg;
                    OFF_MASK:    mask_next = s1_data_reg;
                    OFF_CONTROL:
                    begin
                        // writing a one clears the flag; a zero leaves it
                        ctrl_next[CTL_FLAG]      = ctrl_reg[CTL_FLAG] && !s1_data_reg[CTL_FLAG];
                        ctrl_next[CTL_CLR_MATCH] = s1_data_reg[CTL_CLR_MATCH];
                        ctrl_next[CTL_DEBUG]     = s1_data_reg[CTL_DEBUG];
                        ctrl_next[CTL_ENABLE]    = s1_data_reg[CTL_ENABLE];
                    end
                    OFF_COUNTER: cnt_next  = s1_data_reg;
                    default:     ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            irq_reg       <= 1'b0;
            cmp_reg       <= COMPARE_RESET;
            mask_reg      <= '0;
            ctrl_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                irq_reg       <= ctrl_next[CTL_FLAG];
                cmp_reg       <= cmp_next;
                mask_reg      <= mask_next;
                ctrl_reg      <= ctrl_next;
                cnt_reg       <= cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg   <= mode;
            s1_offset_reg <= offset;
            s1_data_reg   <= write_data;
        end
        if (adv)
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = rdata_reg;
    assign irq       = irq_reg;

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    // ticks never return read data
    a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_mode_reg == MODE_TICK |=> read_data == '0)
        else $error("tick item returned nonzero read_data");

    // clear-on-match zeroes the counter
    a_clr_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_mode_reg == MODE_TICK && ctrl_reg[CTL_ENABLE] && match
            && ctrl_reg[CTL_CLR_MATCH] |=> cnt_reg == '0 && irq_reg)
        else $error("match with clear-on-match did not clear counter or raise irq");

    // a control write with bit 0 set drops the interrupt
    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_mode_reg == MODE_WRITE && s1_offset_reg == OFF_CONTROL
            && s1_data_reg[CTL_FLAG] |=> !ctrl_reg[CTL_FLAG] && !irq_reg)
        else $error("control write failed to clear interrupt flag");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for masked_compare_interrupt_timer: directed and random ticks and register
// accesses, checked against an in-bench model of the timer registers.
// Depends on mcit_pkg and the block's RTL.
import mcit_pkg::*;

class timer_scoreboard;
    typedef struct packed {
        word_t data;
        logic  irq;
    } reply_t;

    word_t  cmp_reg;
    word_t  mask_reg;
    word_t  cnt_reg;
    ctrl_t  ctl_reg;
    reply_t replies_due[$];
    int     errors;

    function new();
        cmp_reg  = COMPARE_RESET;
        mask_reg = '0;
        cnt_reg  = '0;
        ctl_reg  = '0;
        errors   = 0;
    endfunction

    // update the register image for one accepted item and queue its result
    function void note_access(mode_t m, offset_t off, word_t d);
        reply_t r;
        word_t  care;
        logic   flag_kept;
        r.data = '0;
        case (m)
            MODE_TICK:
                if (ctl_reg[CTL_ENABLE])
                begin
                    cnt_reg = cnt_reg + 1;
                    care = ~mask_reg;
                    if ((cnt_reg & care) == (cmp_reg & care))
                    begin
                        ctl_reg[CTL_FLAG] = 1'b1;
                        if (ctl_reg[CTL_CLR_MATCH])
                            cnt_reg = '0;
                    end
                end
            MODE_READ:
                case (off)
                    OFF_COMPARE: r.data = cmp_reg;
                    OFF_MASK:    r.data = mask_reg;
                    OFF_CONTROL: r.data = word_t'(ctl_reg);
                    OFF_COUNTER: r.data = cnt_reg;
                    default:     r.data = '0;
                endcase
            MODE_WRITE:
                case (off)
                    OFF_COMPARE: cmp_reg = d;
                    OFF_MASK:    mask_reg = d;
                    OFF_CONTROL:
                    begin
                        // flag can only be cleared by a write, never set
                        flag_kept = ctl_reg[CTL_FLAG] & ~d[CTL_FLAG];
                        ctl_reg = d[3:0];
                        ctl_reg[CTL_FLAG] = flag_kept;
                    end
                    OFF_COUNTER: cnt_reg = d;
                    default: ;
                endcase
            default: ;
        endcase
        r.irq = ctl_reg[CTL_FLAG];
        replies_due.push_back(r);
    endfunction

    function void check_reply(word_t data, logic irq);
        reply_t exp;
        if (replies_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: read_data %h irq %b", data, irq);
            return;
        end
        exp = replies_due.pop_front();
        if (exp.data !== data || exp.irq !== irq)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: read_data exp %h got %h, irq exp %b got %b",
                         exp.data, data, exp.irq, irq);
        end
    endfunction

    function int pending();
        return replies_due.size();
    endfunction
endclass

module tb;
    localparam mode_t   MODE_NONE     = 2'd3;
    localparam offset_t OFF_UNMAPPED  = 8'hFF;
    localparam offset_t OFF_UNALIGNED = 8'h05;
    localparam int      RANDOM_ITEMS  = 525;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    mode_t   mode;
    offset_t offset;
    word_t   write_data;
    logic    out_valid;
    logic    out_ready;
    word_t   read_data;
    logic    irq;

    timer_scoreboard sb = new();
    int ready_left;

    masked_compare_interrupt_timer DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .offset     (offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .irq        (irq)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_access(mode, offset, write_data);
            if (out_valid && out_ready)
                sb.check_reply(read_data, irq);
        end
    end

    // receiver: ready and stalled stretches of random length
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            if ($urandom_range(0, 4) < 3)
            begin
                out_ready = 1'b1;
                ready_left = $urandom_range(1, 30);
            end
            else
            begin
                out_ready = 1'b0;
                ready_left = $urandom_range(1, 12);
            end
        end
        else
            ready_left--;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(mode_t m, offset_t off, word_t d);
        mode = m;
        offset = off;
        write_data = d;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic offset_t pick_offset();
        if ($urandom_range(0, 99) < 85)
            return offset_t'($urandom_range(0, 3) * 4);
        return offset_t'($urandom_range(0, 255));
    endfunction

    // mostly enabled ticks with compare and counter values near each other, so matches occur
    task automatic pick_item(output mode_t m, output offset_t off, output word_t d);
        int r;
        r = $urandom_range(0, 99);
        m = MODE_TICK;
        off = offset_t'($urandom_range(0, 255));
        d = $urandom;
        if (r >= 50 && r < 65)
        begin
            m = MODE_READ;
            off = pick_offset();
        end
        else if (r >= 65 && r < 92)
        begin
            m = MODE_WRITE;
            off = offset_t'($urandom_range(0, 3) * 4);
            case (off)
                OFF_COMPARE:
                    case ($urandom_range(0, 3))
                        0: d = $urandom;
                        1: d = '1;
                        default: d = sb.cnt_reg + word_t'($urandom_range(1, 12));
                    endcase
                OFF_MASK:
                    case ($urandom_range(0, 3))
                        0: d = '0;
                        1: d = $urandom;
                        2: d = ~word_t'((1 << $urandom_range(1, 6)) - 1);
                        default: d = '1;
                    endcase
                OFF_CONTROL:
                    d[CTL_ENABLE] = ($urandom_range(0, 9) != 0);
                default:
                    case ($urandom_range(0, 3))
                        0: d = $urandom;
                        1: d = '1;
                        2: d = sb.cmp_reg - word_t'($urandom_range(1, 4));
                        default: d = '0;
                    endcase
            endcase
            if ($urandom_range(0, 9) == 0)
                off = offset_t'($urandom_range(0, 255));
        end
        else if (r >= 92 && r < 97)
            m = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
        else if (r >= 97)
            m = MODE_NONE;
    endtask

    initial
    begin
        mode_t   m;
        offset_t off;
        word_t   d;
        int      sent;
        int      burst;
        int      gap;
        int      i;

        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        offset = OFF_COMPARE;
        write_data = '0;
        out_ready = 1'b0;
        ready_left = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values and unmapped reads
        send_item(MODE_READ, OFF_COMPARE, '0);
        send_item(MODE_READ, OFF_MASK, '0);
        send_item(MODE_READ, OFF_CONTROL, '0);
        send_item(MODE_READ, OFF_COUNTER, '0);
        send_item(MODE_READ, OFF_UNMAPPED, '1);
        send_item(MODE_READ, OFF_UNALIGNED, '0);
        send_item(MODE_TICK, OFF_COMPARE, '0);      // disabled: nothing moves
        // match at 3 with clear-on-match
        send_item(MODE_WRITE, OFF_COMPARE, 32'd3);
        send_item(MODE_WRITE, OFF_CONTROL, (1 << CTL_ENABLE) | (1 << CTL_CLR_MATCH));
        repeat (3) send_item(MODE_TICK, OFF_COMPARE, '0);
        send_item(MODE_READ, OFF_COUNTER, '0);
        // full mask: every tick matches, flag already set
        send_item(MODE_WRITE, OFF_MASK, '1);
        send_item(MODE_TICK, OFF_COMPARE, '0);
        // all-ones control write clears the flag and sets the other control bits
        send_item(MODE_WRITE, OFF_CONTROL, '1);
        // counter wrap without match
        send_item(MODE_WRITE, OFF_COUNTER, '1);
        send_item(MODE_WRITE, OFF_MASK, '0);
        send_item(MODE_WRITE, OFF_CONTROL, 1 << CTL_ENABLE);
        send_item(MODE_TICK, OFF_COMPARE, '0);
        // ignored accesses
        send_item(MODE_WRITE, OFF_UNMAPPED, '1);
        send_item(MODE_NONE, OFF_CONTROL, '1);
        send_item(MODE_WRITE, OFF_CONTROL, '0);
        send_item(MODE_TICK, OFF_COMPARE, '0);
        send_item(MODE_READ, OFF_CONTROL, '0);
        in_valid = 1'b0;
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                pick_item(m, off, d);
                send_item(m, off, d);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                begin
                    in_valid = 1'b0;
                    drain();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid = 1'b0;
        drain();
        repeat (5) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
